@@ rtl/plle_pkg.sv @@
// package for the positional list engine: sizes, codes and cell control type
// no dependencies; imported by plle_cell and positional_list_engine_core
`default_nettype none

package plle_pkg;

  // list geometry
  localparam int CAPACITY     = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int LEN_W        = $clog2(CAPACITY + 1);
  localparam int CMP_W        = ((LEN_W > 5) ? LEN_W : 5) + 1;

  // field widths
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // stream widths
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ      = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // per-cell control: load new value, take left neighbor, take right neighbor
  typedef struct packed {
    logic ld;
    logic shr;
    logic shl;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/plle_cell.sv @@
// one storage cell of the list chain, holds a single element
// depends on plle_pkg for widths and the cell control struct
`default_nettype none

module plle_cell (
  input  wire logic                        clk,
  input  wire plle_pkg::cell_ctl_t         ctl,
  input  wire logic [plle_pkg::VALUE_W-1:0] value,
  input  wire logic [plle_pkg::VALUE_W-1:0] prev_data,
  input  wire logic [plle_pkg::VALUE_W-1:0] next_data,
  output logic      [plle_pkg::VALUE_W-1:0] data
);
  import plle_pkg::*;

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;

  // pick the new content: load, shift from left, shift from right or hold
  always_comb begin
    priority if (ctl.ld) begin
      data_nxt = value;
    end else if (ctl.shr) begin
      data_nxt = prev_data;
    end else if (ctl.shl) begin
      data_nxt = next_data;
    end else begin
      data_nxt = data_r;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

@@ rtl/positional_list_engine_core.sv @@
// top level of the positional list engine: command decode, cell chain, result register
// depends on plle_pkg and plle_cell
//
//  channel | ports        | tdata (low bit up)            | tuser (low bit up)
//  --------+--------------+-------------------------------+----------------------------
//  input   | in_t*        | value[31:0], position[36:32]  | op[2:0]
//  result  | out_t*       | count[4:0], item[36:5]        | status[1:0], item_valid[2]
//
// insert and delete: every cell from the touched position onward shifts toward or away
// from it in the same clock, and one result leaves through the output register.
// read out gives min(count, 16) results through one element select, one per cycle unless
// stalled (one itemless if empty); a new command is taken once the last is registered.
// reset clears the element count and the state; the cell contents stay undefined.
// a stalled result holds the output register and blocks new commands.
`default_nettype none

module positional_list_engine_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // value[31:0], position[36:32], zero fill
  input  wire logic [plle_pkg::IN_DATA_W-1:0]    in_tdata,
  // op[2:0]
  input  wire logic [plle_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // count[4:0], item[36:5], zero fill
  output logic      [plle_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[1:0], item_valid[2]
  output logic      [plle_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                                   out_tlast
);
  import plle_pkg::*;

  // input fields
  logic [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]   in_pos;
  op_t                in_op;

  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_pos   = in_tdata[VALUE_W+POS_W-1:VALUE_W];
  assign in_op    = op_t'(in_tuser);

  // control registers
  state_t           st_r, st_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CMP_W-1:0] rd_k_r, rd_k_nxt;
  logic             out_valid_r, out_valid_nxt;

  // result payload registers
  status_t            res_status_r, res_status_nxt;
  logic [COUNT_W-1:0] res_count_r, res_count_nxt;
  logic [VALUE_W-1:0] res_item_r, res_item_nxt;
  logic               res_iv_r, res_iv_nxt;
  logic               res_last_r, res_last_nxt;

  // chain signals
  cell_ctl_t          ctl   [CAPACITY];
  logic [VALUE_W-1:0] cell_q[CAPACITY];
  logic [VALUE_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_sel;

  logic             slot_free;
  logic             accept;
  logic [CMP_W-1:0] len_x;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] idx;
  logic [CMP_W-1:0] rd_n;
  logic             do_ins;
  logic             do_del;
  logic             full;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (st_r == S_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;
  assign len_x     = CMP_W'(len_r);
  assign pos_x     = CMP_W'(in_pos);
  assign full      = (len_x == CMP_W'(CAPACITY));
  assign rd_n      = (len_x > CMP_W'(RESULT_LIMIT)) ? CMP_W'(RESULT_LIMIT) : len_x;

  // element select for read out
  assign rd_sel  = (st_r == S_READ) ? rd_k_r[IDX_W-1:0] : '0;
  assign rd_data = cell_q[rd_sel];

  // command decode, length update and result loading
  always_comb begin
    st_nxt         = st_r;
    len_nxt        = len_r;
    rd_k_nxt       = rd_k_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    res_item_nxt   = res_item_r;
    res_iv_nxt     = res_iv_r;
    res_last_nxt   = res_last_r;
    do_ins         = 1'b0;
    do_del         = 1'b0;
    idx            = '0;

    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          res_status_nxt = STAT_DONE;
          res_item_nxt   = '0;
          res_iv_nxt     = 1'b0;
          res_last_nxt   = 1'b1;
          unique case (in_op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              if (in_op == OP_INS_FRONT) begin
                idx = '0;
              end else if (in_op == OP_INS_BACK) begin
                idx = len_x;
              end else begin
                idx = pos_x - CMP_W'(1);
              end
              if (in_op == OP_INS_AT && (pos_x == '0 || pos_x > len_x + CMP_W'(1))) begin
                res_status_nxt = STAT_BADPOS;
              end else if (full) begin
                res_status_nxt = STAT_FULL;
              end else begin
                do_ins  = 1'b1;
                len_nxt = len_r + LEN_W'(1);
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
              idx = (in_op == OP_DEL_FRONT) ? '0 : len_x - CMP_W'(1);
              if (len_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                do_del  = 1'b1;
                len_nxt = len_r - LEN_W'(1);
              end
            end
            OP_DEL_AT: begin
              idx = pos_x - CMP_W'(1);
              if (pos_x == '0 || pos_x > len_x) begin
                res_status_nxt = STAT_BADPOS;
              end else begin
                do_del  = 1'b1;
                len_nxt = len_r - LEN_W'(1);
              end
            end
            OP_READ: begin
              if (len_r != '0) begin
                res_item_nxt = rd_data;
                res_iv_nxt   = 1'b1;
                res_last_nxt = (rd_n == CMP_W'(1));
                if (rd_n != CMP_W'(1)) begin
                  st_nxt   = S_READ;
                  rd_k_nxt = CMP_W'(1);
                end
              end
            end
            default: begin
              // undefined code, plain done result
            end
          endcase
          res_count_nxt = COUNT_W'(len_nxt);
        end
      end
      S_READ: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          res_status_nxt = STAT_DONE;
          res_count_nxt  = COUNT_W'(len_r);
          res_item_nxt   = rd_data;
          res_iv_nxt     = 1'b1;
          res_last_nxt   = (rd_k_r + CMP_W'(1) == rd_n);
          if (rd_k_r + CMP_W'(1) == rd_n) begin
            st_nxt = S_IDLE;
          end else begin
            rd_k_nxt = rd_k_r + CMP_W'(1);
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // per-cell shift controls
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].ld  = do_ins && (CMP_W'(i) == idx);
      ctl[i].shr = do_ins && (CMP_W'(i) > idx);
      ctl[i].shl = do_del && (CMP_W'(i) >= idx);
    end
  end

  // the cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_W-1:0] prev_d;
    logic [VALUE_W-1:0] next_d;
    if (g == 0) begin : g_first
      assign prev_d = in_value;
    end else begin : g_mid_l
      assign prev_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_d = cell_q[g];
    end else begin : g_mid_r
      assign next_d = cell_q[g+1];
    end
    plle_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[g]),
      .value     (in_value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_q[g])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      len_r       <= '0;
      rd_k_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      len_r       <= len_nxt;
      rd_k_r      <= rd_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    res_item_r   <= res_item_nxt;
    res_iv_r     <= res_iv_nxt;
    res_last_r   <= res_last_nxt;
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - COUNT_W - VALUE_W)'(0), res_item_r, res_count_r};
  assign out_tuser  = {res_iv_r, res_status_r};
  assign out_tlast  = res_last_r;

endmodule

`default_nettype wire
